/* rtl/gcsw_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gcsw_pkg: shared constants and helpers for the heap block sweeper
// Field widths, configuration register indexes, result kinds and the width
// helpers that the front end, back end and top level agree on.
// ----------------------------------------------------------------------------
package gcsw_pkg;

    // Default geometry
    localparam int BLOCK_WORDS_DEF    = 512;
    localparam int MARK_WORD_BITS_DEF = 64;
    localparam int HEADER_WORDS_DEF   = 0;
    localparam int ADDR_BITS_DEF      = 48;

    // Fixed field widths of the channels
    localparam int MARK_W      = 64;
    localparam int ADDR_W      = 48;
    localparam int CLEAR_W     = 8;
    localparam int FOUND_W     = 10;
    localparam int OBJ_WORDS_W = 9;
    localparam int MAX_OBJ_WORDS = 256;

    // Configuration port
    localparam int CFG_DATA_W  = 9;
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_OBJECT_WORDS = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CLEAR_MODE   = 1'd1;

    // Result kinds
    localparam logic KIND_PUSH   = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    // Width of a word offset inside the block, with room for one window
    // past the end and two object sizes of overshoot
    function automatic int start_width(input int block_words, input int mark_bits);
        start_width = $clog2(block_words + mark_bits + 2 * MAX_OBJ_WORDS + 1);
    endfunction

    // Addresses wrap at the narrower of the address space and the field
    function automatic int addr_width(input int addr_bits);
        addr_width = (addr_bits < ADDR_W) ? addr_bits : ADDR_W;
    endfunction

endpackage
`default_nettype wire

/* rtl/gcsw_ifs.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gcsw_ifs: item channels of the heap block sweeper
// Mark word channel into the block and free list result channel out of it,
// each a valid/ready handshake with its payload.
// ----------------------------------------------------------------------------
interface gcsw_in_if import gcsw_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [MARK_W-1:0] mark_bits;
    logic              first_of_block;
    logic [ADDR_W-1:0] block_addr;
    logic [ADDR_W-1:0] list_head_in;

    modport source (output valid, mark_bits, first_of_block, block_addr, list_head_in,
                    input ready);
    modport sink   (input valid, mark_bits, first_of_block, block_addr, list_head_in,
                    output ready);
endinterface

interface gcsw_out_if import gcsw_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               kind;
    logic [ADDR_W-1:0]  obj_addr;
    logic [ADDR_W-1:0]  link_value;
    logic [CLEAR_W-1:0] clear_words;
    logic               block_done;
    logic [ADDR_W-1:0]  list_head;
    logic [FOUND_W-1:0] words_found;
    logic               last;

    modport source (output valid, kind, obj_addr, link_value, clear_words, block_done,
                    list_head, words_found, last, input ready);
    modport sink   (input valid, kind, obj_addr, link_value, clear_words, block_done,
                    list_head, words_found, last, output ready);
endinterface
`default_nettype wire

/* rtl/gc_block_sweep_free_list_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gc_block_sweep_free_list_top: heap block sweeper
// Sweeps a block of equal-sized objects one mark word at a time and emits a
// free list push for every unmarked object, then the block's close.
// ----------------------------------------------------------------------------
// Each mark word is taken by an intake stage into a two-entry command queue.
// The sweep engine picks up a command in its idle state, then steps through
// the object starts from where the previous word left off up to the end of
// that word's window at one candidate per cycle unless the output stalls it,
// then closes the word. Larger objects give fewer candidates per word, and
// when the size shrinks mid-block the starts below the window are stepped
// over as kept. A stalled output holds the engine whenever a push is ready
// to leave. Pushes leave at up to one per cycle through a registered output.
// Reclaimed objects come out in address order; the last result of each mark
// word has last set, and on the block's final word the last result also
// carries block_done with the new list head and the reclaimed word count.
// Write object_words and clear_mode only while the block is idle.
// ----------------------------------------------------------------------------
module gc_block_sweep_free_list_top import gcsw_pkg::*; #(
    parameter int BLOCK_WORDS    = BLOCK_WORDS_DEF,
    parameter int MARK_WORD_BITS = MARK_WORD_BITS_DEF,
    parameter int HEADER_WORDS   = HEADER_WORDS_DEF,
    parameter int ADDR_BITS      = ADDR_BITS_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    gcsw_in_if.sink                     in_ch,
    gcsw_out_if.source                  out_ch,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int SW    = start_width(BLOCK_WORDS, MARK_WORD_BITS);
    localparam int AW    = addr_width(ADDR_BITS);
    localparam int CMD_W = MARK_WORD_BITS + 2 + SW + 2 * AW;

    logic [OBJ_WORDS_W-1:0] object_words_reg;
    logic                   clear_mode_reg;

    logic                      f_push;
    logic [MARK_WORD_BITS-1:0] f_marks;
    logic                      f_first;
    logic                      f_last;
    logic [SW-1:0]             f_wbase;
    logic [AW-1:0]             f_addr;
    logic [AW-1:0]             f_head;

    logic                      b_pop;
    logic [MARK_WORD_BITS-1:0] b_marks;
    logic                      b_first;
    logic                      b_last;
    logic [SW-1:0]             b_wbase;
    logic [AW-1:0]             b_addr;
    logic [AW-1:0]             b_head;

    logic [CMD_W-1:0] q_wdata;
    logic [CMD_W-1:0] q_rdata;
    logic             q_full;
    logic             q_empty;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            object_words_reg <= OBJ_WORDS_W'(1);
            clear_mode_reg   <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_OBJECT_WORDS: object_words_reg <= cfg_data;
                CFG_CLEAR_MODE:   clear_mode_reg   <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    gcsw_front #(
        .BLOCK_WORDS    (BLOCK_WORDS),
        .MARK_WORD_BITS (MARK_WORD_BITS),
        .ADDR_BITS      (ADDR_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .cmd_full  (q_full),
        .cmd_push  (f_push),
        .cmd_marks (f_marks),
        .cmd_first (f_first),
        .cmd_last  (f_last),
        .cmd_wbase (f_wbase),
        .cmd_addr  (f_addr),
        .cmd_head  (f_head)
    );

    // Pack and unpack the sweep command
    assign q_wdata = {f_marks, f_first, f_last, f_wbase, f_addr, f_head};
    assign {b_marks, b_first, b_last, b_wbase, b_addr, b_head} = q_rdata;

    gcsw_cmd_queue #(
        .WIDTH (CMD_W)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (f_push),
        .wdata (q_wdata),
        .pop   (b_pop),
        .rdata (q_rdata),
        .full  (q_full),
        .empty (q_empty)
    );

    gcsw_back #(
        .BLOCK_WORDS    (BLOCK_WORDS),
        .MARK_WORD_BITS (MARK_WORD_BITS),
        .HEADER_WORDS   (HEADER_WORDS),
        .ADDR_BITS      (ADDR_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .object_words (object_words_reg),
        .clear_mode   (clear_mode_reg),
        .cmd_empty    (q_empty),
        .cmd_marks    (b_marks),
        .cmd_first    (b_first),
        .cmd_last     (b_last),
        .cmd_wbase    (b_wbase),
        .cmd_addr     (b_addr),
        .cmd_head     (b_head),
        .cmd_pop      (b_pop),
        .out_ch       (out_ch)
    );

endmodule
`default_nettype wire

/* rtl/gcsw_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gcsw_front: mark word intake and classification
// Accepts mark words, tracks which word of the block each one is, flags the
// block's last word and queues a sweep command for the back end.
// ----------------------------------------------------------------------------
module gcsw_front import gcsw_pkg::*; #(
    parameter int BLOCK_WORDS    = BLOCK_WORDS_DEF,
    parameter int MARK_WORD_BITS = MARK_WORD_BITS_DEF,
    parameter int ADDR_BITS      = ADDR_BITS_DEF,
    localparam int SW = start_width(BLOCK_WORDS, MARK_WORD_BITS),
    localparam int AW = addr_width(ADDR_BITS)
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    gcsw_in_if.sink                        in_ch,
    input  wire logic                      cmd_full,
    output logic                           cmd_push,
    output logic [MARK_WORD_BITS-1:0]      cmd_marks,
    output logic                           cmd_first,
    output logic                           cmd_last,
    output logic [SW-1:0]                  cmd_wbase,
    output logic [AW-1:0]                  cmd_addr,
    output logic [AW-1:0]                  cmd_head
);

    localparam int NUM_WORDS = (BLOCK_WORDS + MARK_WORD_BITS - 1) / MARK_WORD_BITS;
    localparam int IW        = $clog2(NUM_WORDS);
    localparam logic [IW-1:0] LAST_IDX = IW'(NUM_WORDS - 1);

    logic [IW-1:0] idx_reg;
    logic [IW-1:0] idx_next;
    logic [IW-1:0] idx_cur;

    // Take an item whenever the queue has room
    assign in_ch.ready = !cmd_full;
    assign cmd_push    = in_ch.valid && !cmd_full;

    // Restart at word zero on a new block; stay on the last word past the end
    assign idx_cur  = in_ch.first_of_block ? '0 : idx_reg;
    assign cmd_last = (idx_cur == LAST_IDX);
    assign idx_next = cmd_last ? idx_cur : idx_cur + 1'b1;

    assign cmd_marks = in_ch.mark_bits[MARK_WORD_BITS-1:0];
    assign cmd_first = in_ch.first_of_block;
    assign cmd_wbase = SW'(idx_cur * MARK_WORD_BITS);
    assign cmd_addr  = in_ch.block_addr[AW-1:0];
    assign cmd_head  = in_ch.list_head_in[AW-1:0];

    // Advance the word index on each accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else if (cmd_push)
        begin
            idx_reg <= idx_next;
        end
    end

endmodule
`default_nettype wire

/* rtl/gcsw_cmd_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gcsw_cmd_queue: two-entry command queue
// Decouples the intake from the sweep engine so that each side stalls on
// its own.
// ----------------------------------------------------------------------------
module gcsw_cmd_queue #(
    parameter int WIDTH = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rdata,
    output logic                  full,
    output logic                  empty
);

    localparam int DEPTH = 2;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;

    assign full  = (count_reg == 2'(DEPTH));
    assign empty = (count_reg == 2'd0);
    assign rdata = mem_reg[rd_ptr_reg];

    // Store the item at the write pointer
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule
`default_nettype wire

/* rtl/gcsw_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gcsw_back: sweep engine
// Walks the object starts of one mark word, one candidate per cycle while the
// output does not stall it, pushes each unmarked object onto the free list
// and reports the block's close. One push is held back so that the step's
// last result can be flagged.
module gcsw_back import gcsw_pkg::*; #(
    parameter int BLOCK_WORDS    = BLOCK_WORDS_DEF,
    parameter int MARK_WORD_BITS = MARK_WORD_BITS_DEF,
    parameter int HEADER_WORDS   = HEADER_WORDS_DEF,
    parameter int ADDR_BITS      = ADDR_BITS_DEF,
    localparam int SW = start_width(BLOCK_WORDS, MARK_WORD_BITS),
    localparam int AW = addr_width(ADDR_BITS)
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic [OBJ_WORDS_W-1:0]    object_words,
    input  wire logic                      clear_mode,
    input  wire logic                      cmd_empty,
    input  wire logic [MARK_WORD_BITS-1:0] cmd_marks,
    input  wire logic                      cmd_first,
    input  wire logic                      cmd_last,
    input  wire logic [SW-1:0]             cmd_wbase,
    input  wire logic [AW-1:0]             cmd_addr,
    input  wire logic [AW-1:0]             cmd_head,
    output logic                           cmd_pop,
    gcsw_out_if.source                     out_ch
);

    localparam int MIW = $clog2(MARK_WORD_BITS);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic state_reg, state_next;

    // Current command
    logic [MARK_WORD_BITS-1:0] marks_reg;
    logic                      blk_last_reg;
    logic [SW-1:0]             wbase_reg;

    // Sweep state
    logic [SW-1:0]      start_reg, start_next;
    logic [AW-1:0]      base_reg, base_next;
    logic [AW-1:0]      head_reg, head_next;
    logic [FOUND_W-1:0] found_reg, found_next;

    // Held push
    logic               pend_valid_reg, pend_valid_next;
    logic               pend_load;
    logic [AW-1:0]      pend_obj_reg;
    logic [AW-1:0]      pend_link_reg;
    logic [CLEAR_W-1:0] pend_clr_reg;
    logic [AW-1:0]      pend_head_reg;
    logic [FOUND_W-1:0] pend_found_reg;

    // Output register
    logic               out_valid_reg, out_valid_next;
    logic               out_load;
    logic               ld_kind, ld_done, ld_last;
    logic [AW-1:0]      ld_obj, ld_link, ld_head;
    logic [CLEAR_W-1:0] ld_clr;
    logic [FOUND_W-1:0] ld_found;
    logic               out_kind_reg, out_done_reg, out_last_reg;
    logic [AW-1:0]      out_obj_reg, out_link_reg, out_head_reg;
    logic [CLEAR_W-1:0] out_clr_reg;
    logic [FOUND_W-1:0] out_found_reg;

    // Datapath
    logic [OBJ_WORDS_W-1:0] sz;
    logic [SW-1:0]          wend;
    logic [SW-1:0]          start_sum;
    logic [SW-1:0]          diff;
    logic                   cont;
    logic                   free_obj;
    logic                   out_free;
    logic [AW-1:0]          obj_addr;
    logic [FOUND_W-1:0]     found_sum;
    logic [CLEAR_W-1:0]     clr;

    // Clamp the object size into its legal range
    always_comb
    begin
        if (object_words == '0)
        begin
            sz = OBJ_WORDS_W'(1);
        end
        else if (object_words > OBJ_WORDS_W'(MAX_OBJ_WORDS))
        begin
            sz = OBJ_WORDS_W'(MAX_OBJ_WORDS);
        end
        else
        begin
            sz = object_words;
        end
    end

    assign wend      = wbase_reg + SW'(MARK_WORD_BITS);
    assign start_sum = start_reg + SW'(sz);
    assign cont      = (start_reg < wend) && (start_sum <= SW'(BLOCK_WORDS));
    assign diff      = start_reg - wbase_reg;
    assign free_obj  = (start_reg >= wbase_reg) && !marks_reg[diff[MIW-1:0]];
    assign obj_addr  = base_reg + AW'(start_reg);
    assign found_sum = found_reg + FOUND_W'(sz);
    assign clr       = clear_mode ? CLEAR_W'(sz - 1'b1) : '0;
    assign out_free  = !out_valid_reg || out_ch.ready;

    // Sequence the sweep of one mark word
    always_comb
    begin
        state_next      = state_reg;
        start_next      = start_reg;
        base_next       = base_reg;
        head_next       = head_reg;
        found_next      = found_reg;
        pend_valid_next = pend_valid_reg;
        pend_load       = 1'b0;
        cmd_pop         = 1'b0;
        out_load        = 1'b0;
        ld_kind         = KIND_PUSH;
        ld_obj          = pend_obj_reg;
        ld_link         = pend_link_reg;
        ld_clr          = pend_clr_reg;
        ld_done         = 1'b0;
        ld_head         = pend_head_reg;
        ld_found        = pend_found_reg;
        ld_last         = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop    = 1'b1;
                    state_next = ST_RUN;
                    if (cmd_first)
                    begin
                        base_next  = cmd_addr;
                        head_next  = cmd_head;
                        found_next = '0;
                        start_next = SW'(HEADER_WORDS);
                    end
                end
            end
            ST_RUN:
            begin
                if (cont)
                begin
                    if (!free_obj)
                    begin
                        start_next = start_sum;
                    end
                    else if (!pend_valid_reg || out_free)
                    begin
                        // Release the held push and hold this one
                        out_load        = pend_valid_reg;
                        pend_load       = 1'b1;
                        pend_valid_next = 1'b1;
                        head_next       = obj_addr;
                        found_next      = found_sum;
                        start_next      = start_sum;
                    end
                end
                else if (pend_valid_reg)
                begin
                    // Close the step on the held push
                    if (out_free)
                    begin
                        out_load        = 1'b1;
                        ld_done         = blk_last_reg;
                        ld_last         = 1'b1;
                        pend_valid_next = 1'b0;
                        state_next      = ST_IDLE;
                    end
                end
                else if (blk_last_reg)
                begin
                    // Nothing freed on the last word: report only
                    if (out_free)
                    begin
                        out_load   = 1'b1;
                        ld_kind    = KIND_REPORT;
                        ld_obj     = '0;
                        ld_link    = '0;
                        ld_clr     = '0;
                        ld_done    = 1'b1;
                        ld_head    = head_reg;
                        ld_found   = found_reg;
                        ld_last    = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid_next = out_load || (out_valid_reg && !out_ch.ready);
    end

    // Control and sweep state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            start_reg      <= '0;
            base_reg       <= '0;
            head_reg       <= '0;
            found_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            start_reg      <= start_next;
            base_reg       <= base_next;
            head_reg       <= head_next;
            found_reg      <= found_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            marks_reg    <= cmd_marks;
            blk_last_reg <= cmd_last;
            wbase_reg    <= cmd_wbase;
        end
        if (pend_load)
        begin
            pend_obj_reg   <= obj_addr;
            pend_link_reg  <= head_reg;
            pend_clr_reg   <= clr;
            pend_head_reg  <= obj_addr;
            pend_found_reg <= found_sum;
        end
        if (out_load)
        begin
            out_kind_reg  <= ld_kind;
            out_obj_reg   <= ld_obj;
            out_link_reg  <= ld_link;
            out_clr_reg   <= ld_clr;
            out_done_reg  <= ld_done;
            out_head_reg  <= ld_head;
            out_found_reg <= ld_found;
            out_last_reg  <= ld_last;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.kind        = out_kind_reg;
    assign out_ch.obj_addr    = ADDR_W'(out_obj_reg);
    assign out_ch.link_value  = ADDR_W'(out_link_reg);
    assign out_ch.clear_words = out_clr_reg;
    assign out_ch.block_done  = out_done_reg;
    assign out_ch.list_head   = ADDR_W'(out_head_reg);
    assign out_ch.words_found = out_found_reg;
    assign out_ch.last        = out_last_reg;

endmodule
`default_nettype wire

/* sim/gc_block_sweep_free_list_top_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gc_block_sweep_free_list_top_test: self-checking bench for the block sweeper
// Feeds mark words through the item channel and keeps its own model of the
// sweep: block base, free list head, reclaimed word count and the next object
// start. Every push and block-done report coming out is checked field by
// field against the oldest predicted result, under changing object sizes,
// clear modes and idle/stall patterns on both channels.
// ----------------------------------------------------------------------------
module gc_block_sweep_free_list_top_test;
    import gcsw_pkg::*;

    localparam int BLOCK_WORDS    = BLOCK_WORDS_DEF;
    localparam int MARK_BITS      = MARK_WORD_BITS_DEF;
    localparam int HEADER_WORDS   = HEADER_WORDS_DEF;
    localparam int NUM_MARK_WORDS = (BLOCK_WORDS + MARK_BITS - 1) / MARK_BITS;
    localparam int MAX_RESULTS    = 64;
    // after a mid-block size change the walk may begin well below the window,
    // so settle long enough for the engine's command and each queued one
    localparam int SETTLE_CYCLES  = 1024;
    localparam int LIMIT_CYCLES   = 1000000;
    localparam int MAX_GAP        = 40;
    localparam int SEGMENTS       = 12;
    localparam int SEGMENT_ITEMS  = 30;

    typedef struct {
        logic               kind;
        logic [ADDR_W-1:0]  obj_addr;
        logic [ADDR_W-1:0]  link_value;
        logic [CLEAR_W-1:0] clear_words;
        logic               block_done;
        logic [ADDR_W-1:0]  list_head;
        logic [FOUND_W-1:0] words_found;
        logic               last;
    } sweep_result_t;

    logic clk;
    logic rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    gcsw_in_if  in_ch ();
    gcsw_out_if out_ch ();

    gc_block_sweep_free_list_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Model of the sweeper's registers and state
    logic [OBJ_WORDS_W-1:0] obj_words_reg;
    logic                   clear_reg;
    int unsigned            next_start;
    int unsigned            word_idx;
    logic [ADDR_W-1:0]      base_addr;
    logic [ADDR_W-1:0]      head_ptr;
    logic [FOUND_W-1:0]     found_words;

    sweep_result_t sweep_results_due [$];

    int idle_pct;
    int stall_pct;
    int cycle_count;
    int error_count;
    int items_sent;
    int blocks_started;
    int results_checked;
    int reports_seen;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Cycle limit
    initial
    begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: run exceeded %0d cycles", $time, LIMIT_CYCLES);
        $display("FAIL");
        $finish;
    end

    // Result receiver: stall at the phase's rate
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            out_ch.ready <= (stall_pct == 0) ? 1'b1 : ($urandom_range(99) >= stall_pct);
        end
    end

    // Work out the pushes and report caused by one accepted mark word
    function automatic void sweep_mark_word(input logic [MARK_W-1:0] marks,
                                            input logic first,
                                            input logic [ADDR_W-1:0] blk,
                                            input logic [ADDR_W-1:0] head_in);
        sweep_result_t batch [MAX_RESULTS];
        int          n;
        int unsigned sz;
        int unsigned wbase;
        int unsigned wend;
        int unsigned start;
        bit          at_last;
        bit          marked;
        n  = 0;
        sz = obj_words_reg;
        if (sz == 0)
            sz = 1;
        if (sz > MAX_OBJ_WORDS)
            sz = MAX_OBJ_WORDS;
        if (first)
        begin
            base_addr   = blk;
            head_ptr    = head_in;
            found_words = '0;
            word_idx    = 0;
            next_start  = HEADER_WORDS;
        end
        if (word_idx > NUM_MARK_WORDS - 1)
            word_idx = NUM_MARK_WORDS - 1;
        at_last = (word_idx == NUM_MARK_WORDS - 1);
        wbase   = word_idx * MARK_BITS;
        wend    = wbase + MARK_BITS;
        // walk the object starts in this word's window
        while (n < MAX_RESULTS && next_start < wend && next_start + sz <= BLOCK_WORDS)
        begin
            start  = next_start;
            // an object whose mark bit lay in an earlier word is kept
            marked = 1'b1;
            if (start >= wbase)
                marked = marks[start - wbase];
            if (!marked)
            begin
                batch[n].kind        = KIND_PUSH;
                batch[n].obj_addr    = base_addr + ADDR_W'(start);
                batch[n].link_value  = head_ptr;
                head_ptr             = batch[n].obj_addr;
                found_words          = found_words + FOUND_W'(sz);
                batch[n].clear_words = clear_reg ? CLEAR_W'(sz - 1) : '0;
                batch[n].block_done  = 1'b0;
                batch[n].list_head   = head_ptr;
                batch[n].words_found = found_words;
                batch[n].last        = 1'b0;
                n++;
            end
            next_start = start + sz;
        end
        // close the block on its last word, on a push if there was one
        if (at_last)
        begin
            if (n > 0)
                batch[n-1].block_done = 1'b1;
            else
            begin
                batch[0].kind        = KIND_REPORT;
                batch[0].obj_addr    = '0;
                batch[0].link_value  = '0;
                batch[0].clear_words = '0;
                batch[0].block_done  = 1'b1;
                batch[0].list_head   = head_ptr;
                batch[0].words_found = found_words;
                batch[0].last        = 1'b0;
                n = 1;
            end
        end
        else
            word_idx++;
        if (n > 0)
            batch[n-1].last = 1'b1;
        for (int i = 0; i < n; i++)
            sweep_results_due.push_back(batch[i]);
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            error_count++;
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
        end
    endtask

    // Result checker: compare each accepted item with the oldest prediction
    initial
    begin
        sweep_result_t want;
        forever
        begin
            @(posedge clk);
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
            begin
                if (sweep_results_due.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected result: expected none, actual addr %h head %h",
                             $time, out_ch.obj_addr, out_ch.list_head);
                end
                else
                begin
                    want = sweep_results_due.pop_front();
                    results_checked++;
                    if (want.kind == KIND_REPORT)
                        reports_seen++;
                    check_field("kind", want.kind, out_ch.kind);
                    check_field("obj_addr", want.obj_addr, out_ch.obj_addr);
                    check_field("link_value", want.link_value, out_ch.link_value);
                    check_field("clear_words", want.clear_words, out_ch.clear_words);
                    check_field("block_done", want.block_done, out_ch.block_done);
                    check_field("list_head", want.list_head, out_ch.list_head);
                    check_field("words_found", want.words_found, out_ch.words_found);
                    check_field("last", want.last, out_ch.last);
                end
            end
        end
    end

    // Offer one mark word, hold it until taken, then predict its results.
    // Valid is left high; the next call or a drain decides whether to drop it.
    task automatic send_mark_word(input logic [MARK_W-1:0] marks, input logic first,
                                  input logic [ADDR_W-1:0] blk,
                                  input logic [ADDR_W-1:0] head_in);
        int gap;
        gap = 0;
        while (idle_pct > 0 && gap < MAX_GAP && $urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.mark_bits      <= marks;
        in_ch.first_of_block <= first;
        in_ch.block_addr     <= blk;
        in_ch.list_head_in   <= head_in;
        @(posedge clk);
        while (in_ch.ready !== 1'b1)
            @(posedge clk);
        sweep_mark_word(marks, first, blk, head_in);
        items_sent++;
        if (first)
            blocks_started++;
    endtask

    // Drop valid, wait for every predicted result, then let the engine settle
    task automatic wait_for_results();
        in_ch.valid <= 1'b0;
        while (sweep_results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        if (idx == CFG_OBJECT_WORDS)
            obj_words_reg = data[OBJ_WORDS_W-1:0];
        else
            clear_reg = data[0];
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [MARK_W-1:0] random_marks();
        logic [MARK_W-1:0] a;
        logic [MARK_W-1:0] b;
        logic [MARK_W-1:0] c;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        c = {$urandom, $urandom};
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            2: return a & b & c;
            3: return a | b | c;
            4: return a & b;
            default: return a;
        endcase
    endfunction

    function automatic logic [ADDR_W-1:0] random_addr();
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(7))
            0: return '0;
            1: return {ADDR_W{1'b1}} - ADDR_W'($urandom_range(600));
            default: return r[ADDR_W-1:0];
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] random_size();
        case ($urandom_range(9))
            0: return 9'd1;
            1: return 9'd2;
            2: return CFG_DATA_W'($urandom_range(3, 8));
            3: return CFG_DATA_W'($urandom_range(9, 64));
            4: return CFG_DATA_W'($urandom_range(65, 256));
            5: return 9'd256;
            6: return 9'd0;
            7: return CFG_DATA_W'($urandom_range(257, 511));
            8: return CFG_DATA_W'($urandom_range(1, 4));
            default: return CFG_DATA_W'($urandom_range(100, 255));
        endcase
    endfunction

    task automatic set_idling(input int phase);
        case (phase % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 77; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 77; end
            default: begin idle_pct = 35; stall_pct = 35; end
        endcase
    endtask

    // Words before any block start sweep at base 0 with an empty list
    task automatic test_no_block_started();
        send_mark_word(64'h0, 1'b0, random_addr(), random_addr());
        wait_for_results();
    endtask

    // Wrapping base, all-ones head, edge mark patterns, then a word past the end
    task automatic test_field_extremes();
        logic [MARK_W-1:0] pattern [NUM_MARK_WORDS];
        pattern[0] = 64'h0;
        pattern[1] = '1;
        pattern[2] = 64'h5555_5555_5555_5555;
        pattern[3] = 64'hAAAA_AAAA_AAAA_AAAA;
        pattern[4] = 64'h8000_0000_0000_0001;
        pattern[5] = 64'h7FFF_FFFF_FFFF_FFFE;
        pattern[6] = {$urandom, $urandom};
        pattern[7] = 64'h0;
        write_register(CFG_OBJECT_WORDS, 9'd1);
        write_register(CFG_CLEAR_MODE, 9'd1);
        for (int w = 0; w < NUM_MARK_WORDS; w++)
            send_mark_word(pattern[w], w == 0, 48'hFFFF_FFFF_FFE0, 48'hFFFF_FFFF_FFFF);
        send_mark_word(64'h0, 1'b0, '0, '0);
        wait_for_results();
    endtask

    // Shrink the object size before the last word: a straddling object is kept
    task automatic test_resize_mid_block();
        write_register(CFG_OBJECT_WORDS, 9'd200);
        write_register(CFG_CLEAR_MODE, 9'h1FE);
        for (int w = 0; w < NUM_MARK_WORDS - 1; w++)
            send_mark_word(64'h0, w == 0, random_addr(), '0);
        wait_for_results();
        write_register(CFG_OBJECT_WORDS, 9'd100);
        write_register(CFG_CLEAR_MODE, 9'h001);
        send_mark_word(64'h0, 1'b0, random_addr(), random_addr());
        wait_for_results();
    endtask

    // Sizes above 256 act as 256 and size 0 acts as 1
    task automatic test_size_clamping();
        write_register(CFG_OBJECT_WORDS, 9'd511);
        send_mark_word(64'h0, 1'b1, random_addr(), random_addr());
        wait_for_results();
        write_register(CFG_OBJECT_WORDS, 9'd0);
        send_mark_word({$urandom, $urandom}, 1'b1, random_addr(), random_addr());
        wait_for_results();
    endtask

    // Mostly whole blocks with random marks, plus cut-short blocks, stray
    // words and words past the end, across idling phases and settings
    task automatic test_random_sweeps();
        int                mark_count;
        int                len;
        logic [ADDR_W-1:0] blk;
        logic [ADDR_W-1:0] head_in;
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            wait_for_results();
            set_idling(seg);
            write_register(CFG_OBJECT_WORDS, random_size());
            write_register(CFG_CLEAR_MODE, CFG_DATA_W'($urandom_range(511)));
            mark_count = items_sent + SEGMENT_ITEMS;
            while (items_sent < mark_count)
            begin
                blk     = random_addr();
                head_in = random_addr();
                case ($urandom_range(9))
                    0:
                    begin
                        repeat ($urandom_range(1, 3))
                            send_mark_word(random_marks(), 1'($urandom_range(1)),
                                           random_addr(), random_addr());
                    end
                    1:
                    begin
                        len = $urandom_range(1, NUM_MARK_WORDS - 1);
                        for (int w = 0; w < len; w++)
                            send_mark_word(random_marks(), w == 0, blk, head_in);
                    end
                    default:
                    begin
                        for (int w = 0; w < NUM_MARK_WORDS; w++)
                        begin
                            if (w > 0 && $urandom_range(15) == 0)
                            begin
                                wait_for_results();
                                write_register(CFG_OBJECT_WORDS, random_size());
                            end
                            // later words carry random, ignored addresses
                            if (w == 0)
                                send_mark_word(random_marks(), 1'b1, blk, head_in);
                            else
                                send_mark_word(random_marks(), 1'b0, random_addr(),
                                               random_addr());
                        end
                        if ($urandom_range(3) == 0)
                            repeat ($urandom_range(1, 2))
                                send_mark_word(random_marks(), 1'b0, random_addr(),
                                               random_addr());
                    end
                endcase
            end
        end
        wait_for_results();
    endtask

    initial
    begin
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = CFG_OBJECT_WORDS;
        cfg_data             = '0;
        in_ch.valid          = 1'b0;
        in_ch.mark_bits      = '0;
        in_ch.first_of_block = 1'b0;
        in_ch.block_addr     = '0;
        in_ch.list_head_in   = '0;
        obj_words_reg        = 9'd1;
        clear_reg            = 1'b1;
        next_start           = 0;
        word_idx             = 0;
        base_addr            = '0;
        head_ptr             = '0;
        found_words          = '0;
        idle_pct             = 0;
        stall_pct            = 0;
        error_count          = 0;
        items_sent           = 0;
        blocks_started       = 0;
        results_checked      = 0;
        reports_seen         = 0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_no_block_started();
        set_idling(3);
        test_field_extremes();
        set_idling(2);
        test_resize_mid_block();
        set_idling(1);
        test_size_clamping();
        test_random_sweeps();

        if (sweep_results_due.size() != 0)
        begin
            error_count++;
            $display("%0t: results outstanding: expected 0, actual %0d",
                     $time, sweep_results_due.size());
        end
        $display("Swept %0d mark words over %0d block starts, sizes 0..511, both clear modes,",
                 items_sent, blocks_started);
        $display("four idle/stall phases; %0d results checked (%0d reports), %0d mismatches.",
                 results_checked, reports_seen, error_count);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* sim.f */
rtl/gcsw_pkg.sv
rtl/gcsw_ifs.sv
rtl/gcsw_front.sv
rtl/gcsw_cmd_queue.sv
rtl/gcsw_back.sv
rtl/gc_block_sweep_free_list_top.sv
sim/gc_block_sweep_free_list_top_test.sv
